// File: design/afs_pkg.sv
`default_nettype none

package afs_pkg;

    // size defaults for the store
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // field widths
    localparam int DIM_W   = 9;   // width and height registers
    localparam int COORD_W = 16;  // signed coordinates
    localparam int CHAN_W  = 8;   // one colour channel
    localparam int PIX_W   = 32;  // one stored pixel
    localparam int PROD_W  = 24;  // row times stride plus column, enough for 4096 x 4096
    localparam int COUNT_W = 18;  // width times height of the canvas
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // register index, taken from paddr bit 2
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

    // controller to datapath
    typedef struct packed {
        logic load;     // take the item on the input side
        logic rd;       // read the addressed pixel
        logic fill_wr;  // write one pixel of a fill or clear sweep
        logic wb;       // write back and hand the result to the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic new_fill;   // item on the input side is fill or clear
        logic fill_last;  // sweep is at the last pixel in use
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

`default_nettype wire

// File: design/alpha_blend_frame_store_core.sv
`default_nettype none

// rgba8 frame store with per-pixel alpha blending. each input item carries an
// operation in tuser: write (blend into the addressed pixel), read, fill the
// canvas in use with the source colour, or clear it to zero. every item gives
// exactly one result item: an in-range flag in tuser and, for an in-range read,
// the stored pixel in tdata (zero otherwise). write and read go from acceptance
// to the result register in order: the word address (row times stride, plus
// column) is registered on acceptance, then the memory read is registered, then
// the blend and write-back, which waits for a free output register. fill and
// clear sweep the memory through its single write port, one pixel a cycle. the
// store has no reset value: a pixel must be written, filled or cleared before
// it is read. width and height registers sit at byte addresses 0 and 4 on the
// apb port and must only be changed while no item is in flight

module alpha_blend_frame_store_core
    import afs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // slave side, input items
    input  wire               i_s_tvalid,
    output logic              o_s_tready,
    input  wire  [63:0]       i_s_tdata,   // x_pos, y_pos, red_in, green_in, blue_in, alpha_in
    input  wire  [1:0]        i_s_tuser,   // operation
    // master side, result items
    output logic              o_m_tvalid,
    input  wire               i_m_tready,
    output logic [31:0]       o_m_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic              o_m_tuser,   // in_range
    // configuration
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [APB_AW-1:0] paddr,
    input  wire  [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic             cfg_wr;
    t_cmd             cmd;
    t_sts             sts;
    logic [PIX_W-1:0] pixel;

    // register file, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HEIGHT) ? APB_DW'(r_height) : APB_DW'(r_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(256);
            r_height <= DIM_W'(256);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_width <= pwdata[DIM_W-1:0];
            end else begin
                r_height <= pwdata[DIM_W-1:0];
            end
        end
    end

    // zero acts as one, anything above the store's size acts as the maximum
    always_comb begin
        if (r_width == '0) begin
            width_eff = DIM_W'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            width_eff = DIM_W'(MAX_WIDTH);
        end else begin
            width_eff = r_width;
        end
        if (r_height == '0) begin
            height_eff = DIM_W'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            height_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            height_eff = r_height;
        end
    end

    afs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    afs_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_width    (width_eff),
        .i_height   (height_eff),
        .i_op       (i_s_tuser),
        .i_x        (i_s_tdata[15:0]),
        .i_y        (i_s_tdata[31:16]),
        .i_red      (i_s_tdata[39:32]),
        .i_green    (i_s_tdata[47:40]),
        .i_blue     (i_s_tdata[55:48]),
        .i_alpha    (i_s_tdata[63:56]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_in_range (o_m_tuser),
        .o_pixel    (pixel)
    );

    // stored word is already red in the low byte up to alpha in the top byte
    assign o_m_tdata = pixel;

endmodule

`default_nettype wire

// File: design/afs_ctrl.sv
`default_nettype none

module afs_ctrl
    import afs_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;
    localparam logic [1:0] S_FILL = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.new_fill ? S_FILL : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WB;
            end
            S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (i_sts.out_free) begin
                    o_cmd.wb = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: design/afs_dp.sv
`default_nettype none

module afs_dp
    import afs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  wire  [DIM_W-1:0]   i_width,
    input  wire  [DIM_W-1:0]   i_height,
    input  wire  [1:0]         i_op,
    input  wire  [COORD_W-1:0] i_x,
    input  wire  [COORD_W-1:0] i_y,
    input  wire  [CHAN_W-1:0]  i_red,
    input  wire  [CHAN_W-1:0]  i_green,
    input  wire  [CHAN_W-1:0]  i_blue,
    input  wire  [CHAN_W-1:0]  i_alpha,
    input  wire                i_m_tready,
    output logic               o_m_tvalid,
    output logic               o_in_range,
    output logic [PIX_W-1:0]   o_pixel
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (ADDR_W > COUNT_W) ? ADDR_W : COUNT_W;

    // exact floor(v / 255) for any v up to 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] v);
        logic [16:0] s;
        s = 17'(v) + 17'd1 + 17'(v[15:8]);
        return s[15:8];
    endfunction

    function automatic logic [CHAN_W-1:0] mix(
        input logic [CHAN_W-1:0] old_v,
        input logic [CHAN_W-1:0] new_v,
        input logic [CHAN_W-1:0] a
    );
        logic [15:0] v;
        v = 16'(old_v) * 16'(ALPHA_OPAQUE - a) + 16'(new_v) * 16'(a);
        return div255(v);
    endfunction

    logic [PIX_W-1:0]   r_mem [DEPTH];
    logic [PIX_W-1:0]   r_rdata;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_fill_idx;
    logic [COUNT_W-1:0] r_last;
    logic               r_ok;
    logic [1:0]         r_op;
    logic [CHAN_W-1:0]  r_red;
    logic [CHAN_W-1:0]  r_green;
    logic [CHAN_W-1:0]  r_blue;
    logic [CHAN_W-1:0]  r_alpha;
    logic               r_valid;
    logic               r_out_ok;
    logic [PIX_W-1:0]   r_out_pix;

    logic               x_ok;
    logic               y_ok;
    logic [PROD_W-1:0]  addr_sum;
    logic [COUNT_W-1:0] last_next;
    logic               is_fill;
    logic [PIX_W-1:0]   src_word;
    logic [PIX_W-1:0]   blend_word;
    logic [PIX_W-1:0]   wdata;
    logic [ADDR_W-1:0]  waddr;
    logic               we;
    logic [CHAN_W:0]    alpha_sum;

    // bounds and address of the item on the input side
    assign x_ok      = !i_x[COORD_W-1] && (i_x[COORD_W-2:0] < (COORD_W-1)'(i_width));
    assign y_ok      = !i_y[COORD_W-1] && (i_y[COORD_W-2:0] < (COORD_W-1)'(i_height));
    assign addr_sum  = PROD_W'(i_y[COORD_W-2:0]) * PROD_W'(i_width)
                     + PROD_W'(i_x[COORD_W-2:0]);
    assign last_next = COUNT_W'(i_width) * COUNT_W'(i_height) - COUNT_W'(1);

    assign is_fill = (r_op == OP_FILL) || (r_op == OP_CLEAR);

    assign src_word  = {r_alpha, r_blue, r_green, r_red};
    assign alpha_sum = (CHAN_W+1)'(r_rdata[31:24]) + (CHAN_W+1)'(r_alpha);
    assign blend_word = {alpha_sum[CHAN_W:1],
                         mix(r_rdata[23:16], r_blue,  r_alpha),
                         mix(r_rdata[15:8],  r_green, r_alpha),
                         mix(r_rdata[7:0],   r_red,   r_alpha)};

    always_comb begin
        if (i_cmd.fill_wr) begin
            waddr = r_fill_idx;
            wdata = (r_op == OP_FILL) ? src_word : '0;
            we    = 1'b1;
        end else begin
            waddr = r_addr;
            wdata = (r_alpha == ALPHA_OPAQUE) ? src_word : blend_word;
            we    = i_cmd.wb && (r_op == OP_WRITE) && r_ok && (r_alpha != ALPHA_CLEAR);
        end
    end

    assign o_sts.new_fill  = (i_op == OP_FILL) || (i_op == OP_CLEAR);
    assign o_sts.fill_last = (CMP_W'(r_fill_idx) == CMP_W'(r_last));
    assign o_sts.out_free  = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_addr];
        end
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_red      <= i_red;
            r_green    <= i_green;
            r_blue     <= i_blue;
            r_alpha    <= i_alpha;
            r_ok       <= x_ok && y_ok;
            r_addr     <= addr_sum[ADDR_W-1:0];
            r_last     <= last_next;
            r_fill_idx <= '0;
        end else if (i_cmd.fill_wr) begin
            r_fill_idx <= r_fill_idx + ADDR_W'(1);
        end
        if (i_cmd.wb) begin
            r_out_ok  <= is_fill || r_ok;
            r_out_pix <= ((r_op == OP_READ) && r_ok) ? r_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wb) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_in_range = r_out_ok;
    assign o_pixel    = r_out_pix;

endmodule

`default_nettype wire

// File: test/tb_alpha_blend_frame_store_core.sv
module tb_alpha_blend_frame_store_core;
    timeunit 1ns;
    timeprecision 1ps;

    import afs_pkg::*;

    // run limits in clock cycles
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 16;     // quiet cycles once every result is in
    localparam int HOLDOFF      = 400;    // long receiver stall for the back-pressure test
    localparam int STORE_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int PHASE_ITEMS  = 133;

    // one result item, as the predictor expects it
    typedef struct packed {
        logic             in_range;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pixel_result;

    // block ports, every input known from time zero
    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [63:0]       i_s_tdata  = '0;   // x_pos, y_pos, red_in, green_in, blue_in, alpha_in
    logic [1:0]        i_s_tuser  = OP_READ;   // operation
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [31:0]       o_m_tdata;          // red_out, green_out, blue_out, alpha_out
    logic              o_m_tuser;          // in_range
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [APB_AW-1:0] paddr      = '0;
    logic [APB_DW-1:0] pwdata     = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // predictor state: its own copy of the pixels and of both registers
    logic [PIX_W-1:0]  pixel_mirror [0:STORE_DEPTH-1];
    logic [DIM_W-1:0]  canvas_width  = 9'd256;
    logic [DIM_W-1:0]  canvas_height = 9'd256;
    t_pixel_result     pending_pixels [$];
    t_pixel_result     oldest_pixel;

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  sender_no_idle = 1'b0;
    bit  sink_no_idle   = 1'b0;
    bit  stall_request  = 1'b0;
    int  stall_left     = 0;

    alpha_blend_frame_store_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stalls, a no-stall mode, and a long hold-off counted here
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                stall_left    = HOLDOFF;
                stall_request = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (sink_no_idle) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 33);
            end
        end
    end

    // width or height as the block uses it: zero acts as one, oversize as the maximum
    function automatic int effective_dim(input logic [DIM_W-1:0] value, input int maxv);
        if (value == 0) return 1;
        if (value > maxv) return maxv;
        return value;
    endfunction

    function automatic logic [CHAN_W-1:0] blend_channel(input int oldv, input int newv,
                                                        input int a);
        return CHAN_W'((oldv * (255 - a) + newv * a) / 255);
    endfunction

    // works out the result of one accepted item and updates the pixel copy
    task automatic predict_pixel(input logic [1:0] op, input logic [15:0] x_raw,
                                 input logic [15:0] y_raw, input logic [CHAN_W-1:0] r,
                                 input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
                                 input logic [CHAN_W-1:0] a);
        int               w;
        int               h;
        int               xi;
        int               yi;
        int               idx;
        logic [PIX_W-1:0] cur;
        t_pixel_result    res;
        w   = effective_dim(canvas_width, DEF_MAX_WIDTH);
        h   = effective_dim(canvas_height, DEF_MAX_HEIGHT);
        xi  = $signed(x_raw);
        yi  = $signed(y_raw);
        res = '0;
        if (op == OP_FILL || op == OP_CLEAR) begin
            // sweep covers the first width*height words only
            for (int i = 0; i < w * h; i++)
                pixel_mirror[i] = (op == OP_FILL) ? {a, b, g, r} : '0;
            res.in_range = 1'b1;
        end else if (xi >= 0 && yi >= 0 && xi < w && yi < h) begin
            idx          = xi + yi * w;
            cur          = pixel_mirror[idx];
            res.in_range = 1'b1;
            if (op == OP_READ) begin
                {res.alpha, res.blue, res.green, res.red} = cur;
            end else if (a == ALPHA_OPAQUE) begin
                pixel_mirror[idx] = {a, b, g, r};
            end else if (a != ALPHA_CLEAR) begin
                // colour channels blended, alpha averaged
                pixel_mirror[idx] = {8'((int'(cur[31:24]) + int'(a)) >> 1),
                                     blend_channel(cur[23:16], b, a),
                                     blend_channel(cur[15:8], g, a),
                                     blend_channel(cur[7:0], r, a)};
            end
        end
        pending_pixels.push_back(res);
    endtask

    // offers one item, waits for it to be taken, then predicts it; tvalid stays
    // high so the next item can follow straight on
    task automatic send_item(input logic [1:0] op, input logic [15:0] x_raw,
                             input logic [15:0] y_raw, input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
                             input logic [CHAN_W-1:0] a);
        int gap;
        gap = 0;
        if (!sender_no_idle)
            while ($urandom_range(99) < 33) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {a, b, g, r, y_raw, x_raw};
        do @(posedge i_clk); while (!o_s_tready);
        predict_pixel(op, x_raw, y_raw, r, g, b, a);
    endtask

    // stops offering and waits for every outstanding result, then a quiet spell
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apb write: setup cycle, access cycle, then back to idle;
    // only called with nothing in flight
    task automatic write_register(input logic reg_idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_WIDTH)
            canvas_width = value[DIM_W-1:0];
        else
            canvas_height = value[DIM_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int expected_value,
                               input int actual_value);
        if (expected_value != actual_value) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h",
                     $time, name, expected_value, actual_value);
            mismatch_count++;
        end
    endtask

    // result checker, sampled at the edge so the pre-edge values are seen
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got in_range %0b data %0h",
                         $time, o_m_tuser, o_m_tdata);
                mismatch_count++;
            end else begin
                oldest_pixel = pending_pixels.pop_front();
                check_field("in_range",  oldest_pixel.in_range, o_m_tuser);
                check_field("red_out",   oldest_pixel.red,      o_m_tdata[7:0]);
                check_field("green_out", oldest_pixel.green,    o_m_tdata[15:8]);
                check_field("blue_out",  oldest_pixel.blue,     o_m_tdata[23:16]);
                check_field("alpha_out", oldest_pixel.alpha,    o_m_tdata[31:24]);
            end
        end
    end

    // full-size canvas: the first fill defines every word, so later reads and
    // blends never touch an unwritten pixel
    task automatic test_directed_cases();
        send_item(OP_FILL,  16'd0,    16'd0,    8'h40, 8'h80, 8'hC0, 8'h60);
        send_item(OP_READ,  16'd0,    16'd0,    8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'd255,  16'd255,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // coordinates just outside and at the far signed extremes
        send_item(OP_READ,  16'hFFFF, 16'd0,    8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'd0,    16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'd256,  16'd0,    8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'd0,    16'd256,  8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'h8000, 16'h7FFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'h7FFF, 16'h8000, 8'h00, 8'h00, 8'h00, 8'h00);
        // opaque replace, then transparent leaves it alone
        send_item(OP_WRITE, 16'd0,    16'd0,    8'hFF, 8'h00, 8'hFF, 8'hFF);
        send_item(OP_READ,  16'd0,    16'd0,    8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'd0,    16'd0,    8'h00, 8'hFF, 8'h00, 8'h00);
        send_item(OP_READ,  16'd0,    16'd0,    8'h00, 8'h00, 8'h00, 8'h00);
        // weakest and strongest blends
        send_item(OP_WRITE, 16'd1,    16'd0,    8'hFF, 8'hFF, 8'hFF, 8'h01);
        send_item(OP_WRITE, 16'd1,    16'd0,    8'h00, 8'h00, 8'h00, 8'hFE);
        send_item(OP_READ,  16'd1,    16'd0,    8'h00, 8'h00, 8'h00, 8'h00);
        // writes outside the canvas must not land anywhere
        send_item(OP_WRITE, 16'd256,  16'd3,    8'h11, 8'h22, 8'h33, 8'hFF);
        send_item(OP_WRITE, 16'hFFFF, 16'd3,    8'h11, 8'h22, 8'h33, 8'hFF);
        send_item(OP_READ,  16'd0,    16'd4,    8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'd255,  16'd2,    8'h00, 8'h00, 8'h00, 8'h00);
        // clear, then blend onto black
        send_item(OP_CLEAR, 16'd9,    16'd9,    8'hAA, 8'hAA, 8'hAA, 8'hAA);
        send_item(OP_READ,  16'd17,   16'd200,  8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'd17,   16'd200,  8'hFF, 8'h80, 8'h01, 8'h80);
        send_item(OP_READ,  16'd17,   16'd200,  8'h00, 8'h00, 8'h00, 8'h00);
        wait_drained();
    endtask

    // zero and oversize register values, with junk above the register bits
    task automatic test_register_limits();
        write_register(REG_WIDTH,  32'hFFFF_FE00);   // zero, acts as one
        write_register(REG_HEIGHT, 32'h0000_0000);
        send_item(OP_FILL,  16'd0, 16'd0, 8'h01, 8'h02, 8'h03, 8'h04);
        send_item(OP_READ,  16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'd1, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'd0, 16'd1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'd0, 16'd0, 8'hF0, 8'h0F, 8'h80, 8'h80);
        send_item(OP_READ,  16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_drained();
        write_register(REG_WIDTH,  32'h0000_01FF);   // oversize, acts as the maximum
        write_register(REG_HEIGHT, 32'h0000_012C);
        send_item(OP_READ,  16'd255, 16'd255, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'd256, 16'd0,   8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'd0,   16'd256, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_drained();
        write_register(REG_WIDTH,  32'd1);
        write_register(REG_HEIGHT, 32'd256);
        send_item(OP_READ,  16'd0, 16'd255, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(OP_READ,  16'd1, 16'd0,   8'h00, 8'h00, 8'h00, 8'h00);
        wait_drained();
    endtask

    function automatic logic [15:0] pick_coord(input int dim);
        int k;
        k = $urandom_range(99);
        if (k < 80) return 16'($urandom_range(dim - 1));
        if (k < 84) return 16'hFFFF;
        if (k < 88) return 16'(dim);
        return 16'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [CHAN_W-1:0] pick_alpha();
        int k;
        k = $urandom_range(99);
        if (k < 20) return ALPHA_OPAQUE;
        if (k < 35) return ALPHA_CLEAR;
        if (k < 40) return 8'h01;
        if (k < 45) return 8'hFE;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_item();
        int         k;
        logic [1:0] op;
        k = $urandom_range(99);
        if (k < 2)       op = OP_FILL;
        else if (k < 4)  op = OP_CLEAR;
        else if (k < 44) op = OP_READ;
        else             op = OP_WRITE;
        send_item(op, pick_coord(effective_dim(canvas_width, DEF_MAX_WIDTH)),
                  pick_coord(effective_dim(canvas_height, DEF_MAX_HEIGHT)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), pick_alpha());
    endtask

    // receiver holds off while the sender keeps offering, so the block backs up;
    // afterwards the sender waits for every result before going on
    task automatic test_backpressure();
        write_register(REG_WIDTH,  32'd8);
        write_register(REG_HEIGHT, 32'd8);
        sender_no_idle = 1'b1;
        stall_request  = 1'b1;
        repeat (48) send_random_item();
        sender_no_idle = 1'b0;
        wait_drained();
        repeat (24) send_random_item();
        wait_drained();
    endtask

    // phases of random traffic, each under its own canvas setting
    task automatic test_random_traffic();
        logic [APB_DW-1:0] w_val;
        logic [APB_DW-1:0] h_val;
        for (int phase = 0; phase < 9; phase++) begin
            w_val = $urandom_range(1, 20);
            h_val = $urandom_range(1, 20);
            case (phase)
                3: begin
                    w_val = 32'd256;
                    h_val = $urandom_range(1, 3);
                end
                4: begin
                    w_val = 32'd0;
                    h_val = 32'd256;
                end
                5: begin
                    w_val = $urandom_range(257, 511);
                    h_val = $urandom_range(0, 2);
                end
                default: ;
            endcase
            // junk above the register bits must be dropped
            w_val[APB_DW-1:DIM_W] = (APB_DW-DIM_W)'($urandom);
            h_val[APB_DW-1:DIM_W] = (APB_DW-DIM_W)'($urandom);
            write_register(REG_WIDTH,  w_val);
            write_register(REG_HEIGHT, h_val);
            // one phase runs flat out on both sides
            sender_no_idle = (phase == 6);
            sink_no_idle   = (phase == 6);
            repeat (PHASE_ITEMS) send_random_item();
            wait_drained();
        end
        sender_no_idle = 1'b0;
        sink_no_idle   = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_register_limits();
        test_backpressure();
        test_random_traffic();
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
